### rtl/nsm_pkg.sv
package nsm_pkg;

  // Defaults for the top-level parameters.
  localparam int PIXEL_BITS_DEF = 16;
  localparam int MAX_COLS_DEF   = 64;

  // Configuration register layout.
  localparam int ROWS_BITS     = 11;
  localparam int COLS_BITS     = 7;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 11;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLS = 1'd1;

  // Frame height limit and the row counter that covers it.
  localparam int ROW_LIMIT    = 1024;
  localparam int ROW_CNT_BITS = 10;

  // Result queue.
  localparam int RES_DEPTH    = 8;
  localparam int RES_PTR_BITS = $clog2(RES_DEPTH);

  // Position of an accepted pixel inside the frame.
  typedef struct packed {
    logic c_ge1;       // a column exists to the left
    logic c_ge2;       // two columns exist to the left
    logic last_col;    // rightmost column of the row
    logic has_above1;  // one row above exists
    logic has_above2;  // two rows above exist
    logic last_row;    // bottom row of the frame
    logic last_pix;    // final pixel of the frame
  } pos_flags_t;

endpackage

### rtl/nsm_if.sv
interface nsm_pix_if #(
  parameter int PIXEL_BITS = nsm_pkg::PIXEL_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface nsm_res_if #(
  parameter int PIXEL_BITS = nsm_pkg::PIXEL_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS+3:0] max_sum;
  logic signed [PIXEL_BITS-1:0] center_value;

  modport source (output valid, output max_sum, output center_value, input ready);
  modport sink   (input valid, input max_sum, input center_value, output ready);
endinterface

interface nsm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [nsm_pkg::CFG_IDX_BITS-1:0]  index;
  logic [nsm_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/neighborhood_sum_max_core.sv
// Largest 3x3 neighborhood sum of a frame of signed pixels. Pixels arrive in
// raster order, one word per clock, and the block takes a new word in every
// cycle; the only thing that pulls pixels.ready low is eight result words
// the sink has not yet taken, counting those still in the pipeline as well as
// those in the queue. For every position the block adds the in-frame part of
// its 3x3 neighborhood and keeps the largest sum together with the pixel at
// its centre, the earliest centre in raster order winning a tie. One result
// word (max_sum, center_value) follows on results for each frame.
// The two previous rows live in a chain of column cells that shifts once per
// accepted pixel, and the window and compare pipeline after it also advances
// one column per accepted pixel, which is what sets the rate of one pixel per
// clock. Writing rows or cols restarts the frame; write them only while the
// block is idle. A zero value counts as one, rows above 1024 count as 1024
// and cols above MAX_COLS count as MAX_COLS.
module neighborhood_sum_max_core #(
  parameter int PIXEL_BITS = nsm_pkg::PIXEL_BITS_DEF,
  parameter int MAX_COLS   = nsm_pkg::MAX_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  nsm_pix_if.sink    pixels,
  nsm_res_if.source  results,
  nsm_cfg_if.sink    cfg
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = nsm_pkg::ROW_CNT_BITS;
  localparam int OW = nsm_pkg::RES_PTR_BITS + 1;

  // Handshakes. Configuration is always taken.
  logic pix_acc, res_acc, cfg_acc;

  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid && cfg.ready;
  assign pix_acc   = pixels.valid && pixels.ready;
  assign res_acc   = results.valid && results.ready;

  // Frame size, stored as the index of the last row and column. The limits
  // are applied when the register is written, so the counters compare
  // against them directly.
  logic [RW-1:0]                     rows_m1;
  logic [CW-1:0]                     cols_m1;
  logic [nsm_pkg::ROWS_BITS-1:0]     rows_v;
  logic [nsm_pkg::COLS_BITS-1:0]     cols_v;
  logic [RW-1:0]                     rows_m1_next;
  logic [CW-1:0]                     cols_m1_next;

  assign rows_v = cfg.data[nsm_pkg::ROWS_BITS-1:0];
  assign cols_v = cfg.data[nsm_pkg::COLS_BITS-1:0];

  always_comb begin
    if (rows_v == '0) begin
      rows_m1_next = '0;
    end else if (32'(rows_v) > nsm_pkg::ROW_LIMIT) begin
      rows_m1_next = RW'(nsm_pkg::ROW_LIMIT - 1);
    end else begin
      rows_m1_next = RW'(rows_v - nsm_pkg::ROWS_BITS'(1));
    end
    if (cols_v == '0) begin
      cols_m1_next = '0;
    end else if (32'(cols_v) > MAX_COLS) begin
      cols_m1_next = CW'(MAX_COLS - 1);
    end else begin
      cols_m1_next = CW'(cols_v - nsm_pkg::COLS_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m1 <= '0;
      cols_m1 <= '0;
    end else if (cfg_acc) begin
      case (cfg.index)
        nsm_pkg::CFG_ROWS: begin
          rows_m1 <= rows_m1_next;
        end
        nsm_pkg::CFG_COLS: begin
          cols_m1 <= cols_m1_next;
        end
        default: begin
        end
      endcase
    end
  end

  // Position of the next pixel. Any configuration write starts a new frame.
  logic [RW-1:0]       row_cnt;
  logic [CW-1:0]       col_cnt;
  nsm_pkg::pos_flags_t flags;

  always_comb begin
    flags.c_ge1      = (col_cnt != '0);
    flags.c_ge2      = (col_cnt != '0) && (col_cnt != CW'(1));
    flags.last_col   = (col_cnt == cols_m1);
    flags.has_above1 = (row_cnt != '0);
    flags.has_above2 = (row_cnt != '0) && (row_cnt != RW'(1));
    flags.last_row   = (row_cnt == rows_m1);
    flags.last_pix   = (col_cnt == cols_m1) && (row_cnt == rows_m1);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_acc) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (pix_acc) begin
      if (flags.last_col) begin
        col_cnt <= '0;
        if (flags.last_row) begin
          row_cnt <= '0;
        end else begin
          row_cnt <= row_cnt + RW'(1);
        end
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // Line stores as a chain of column cells. The cell at the last column
  // takes the incoming pixel into the newer line and the word leaving
  // cell 0 into the older line; all others take their right neighbor. After
  // one row of shifts, cell 0 holds the pixels one and two rows above the
  // column that arrives next.
  logic signed [PIXEL_BITS-1:0] cell_newer [MAX_COLS];
  logic signed [PIXEL_BITS-1:0] cell_older [MAX_COLS];

  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    logic signed [PIXEL_BITS-1:0] right_newer, right_older;

    if (i == MAX_COLS - 1) begin : g_end
      assign right_newer = '0;
      assign right_older = '0;
    end else begin : g_mid
      assign right_newer = cell_newer[i+1];
      assign right_older = cell_older[i+1];
    end

    nsm_cell #(
      .PIXEL_BITS (PIXEL_BITS),
      .COL_BITS   (CW),
      .INDEX      (i)
    ) u_cell (
      .clk         (clk),
      .shift       (pix_acc),
      .cols_m1     (cols_m1),
      .new_newer   (pixels.pixel),
      .new_older   (cell_newer[0]),
      .right_newer (right_newer),
      .right_older (right_older),
      .newer       (cell_newer[i]),
      .older       (cell_older[i])
    );
  end

  // Window, sums and maxima.
  logic                         push;
  logic signed [PIXEL_BITS+3:0] push_sum;
  logic signed [PIXEL_BITS-1:0] push_center;

  nsm_judge #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_judge (
    .clk         (clk),
    .rst         (rst),
    .clear       (cfg_acc),
    .acc         (pix_acc),
    .flags       (flags),
    .older       (cell_older[0]),
    .newer       (cell_newer[0]),
    .pix         (pixels.pixel),
    .push        (push),
    .push_sum    (push_sum),
    .push_center (push_center)
  );

  nsm_res_fifo #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_sum    (push_sum),
    .push_center (push_center),
    .results     (results)
  );

  // Result words owed to the sink: those still in the pipeline plus those
  // waiting in the queue. Input stops only when the queue could overflow.
  logic [OW-1:0] owed;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else begin
      if ((pix_acc && flags.last_pix) && !res_acc) begin
        owed <= owed + OW'(1);
      end else if (res_acc && !(pix_acc && flags.last_pix)) begin
        owed <= owed - OW'(1);
      end
    end
  end

  assign pixels.ready = (owed != OW'(nsm_pkg::RES_DEPTH));

  // A word on the output must have been counted as owed.
  a_valid_owed: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (owed != '0))
    else $error("result word offered with none owed");

  // The last pixel of a frame adds one owed result word unless a word is taken at the same time.
  a_last_counts: assert property (@(posedge clk) disable iff (rst)
    (pix_acc && flags.last_pix && !res_acc) |=> (owed == $past(owed) + OW'(1)))
    else $error("last pixel did not raise the owed count");

  // The column counter stays inside the configured row width.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col_cnt <= cols_m1)
    else $error("column counter beyond the last column");

  // With eight result words owed, no pixel may be accepted, so no word is lost.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (owed == OW'(nsm_pkg::RES_DEPTH)) |-> !pix_acc)
    else $error("pixel accepted with the result queue full");

endmodule

### rtl/nsm_cell.sv
// One column slot of the two line stores. The slot whose index equals the
// last column takes new data; every other slot takes its right neighbor.
module nsm_cell #(
  parameter int PIXEL_BITS = nsm_pkg::PIXEL_BITS_DEF,
  parameter int COL_BITS   = 6,
  parameter int INDEX      = 0
) (
  input  logic                         clk,
  input  logic                         shift,
  input  logic [COL_BITS-1:0]          cols_m1,
  input  logic signed [PIXEL_BITS-1:0] new_newer,
  input  logic signed [PIXEL_BITS-1:0] new_older,
  input  logic signed [PIXEL_BITS-1:0] right_newer,
  input  logic signed [PIXEL_BITS-1:0] right_older,
  output logic signed [PIXEL_BITS-1:0] newer,
  output logic signed [PIXEL_BITS-1:0] older
);

  logic tail;

  assign tail = (cols_m1 == COL_BITS'(INDEX));

  always_ff @(posedge clk) begin
    if (shift) begin
      newer <= tail ? new_newer : right_newer;
      older <= tail ? new_older : right_older;
    end
  end

endmodule

### rtl/nsm_judge.sv
// Column sums, a three-column window and the running maxima. Candidates of
// the bottom row are kept apart from those of the rows above and merged at
// the end of the frame, so raster order decides ties.
module nsm_judge #(
  parameter int PIXEL_BITS = nsm_pkg::PIXEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         acc,
  input  nsm_pkg::pos_flags_t          flags,
  input  logic signed [PIXEL_BITS-1:0] older,
  input  logic signed [PIXEL_BITS-1:0] newer,
  input  logic signed [PIXEL_BITS-1:0] pix,
  output logic                         push,
  output logic signed [PIXEL_BITS+3:0] push_sum,
  output logic signed [PIXEL_BITS-1:0] push_center
);

  localparam int CSW = PIXEL_BITS + 2;
  localparam int SW  = PIXEL_BITS + 4;
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

  // Column sums of the accepted pixel.
  logic signed [PIXEL_BITS-1:0] a_g, n_g;
  logic signed [CSW-1:0]        col_u, col_l;

  always_comb begin
    if (flags.has_above2) begin
      a_g = older;
    end else begin
      a_g = '0;
    end
    if (flags.has_above1) begin
      n_g = newer;
    end else begin
      n_g = '0;
    end
    col_u = CSW'(a_g) + CSW'(n_g) + CSW'(pix);
    col_l = CSW'(n_g) + CSW'(pix);
  end

  // Window of the three newest columns; index 0 is the newest.
  logic signed [CSW-1:0]        w_u [3];
  logic signed [CSW-1:0]        w_l [3];
  logic signed [PIXEL_BITS-1:0] w_n [2];
  logic signed [PIXEL_BITS-1:0] w_p [2];
  nsm_pkg::pos_flags_t          w_f;
  logic                         s1_valid;

  always_ff @(posedge clk) begin
    if (acc) begin
      w_u[0] <= col_u;
      w_u[1] <= w_u[0];
      w_u[2] <= w_u[1];
      w_l[0] <= col_l;
      w_l[1] <= w_l[0];
      w_l[2] <= w_l[1];
      w_n[0] <= newer;
      w_n[1] <= w_n[0];
      w_p[0] <= pix;
      w_p[1] <= w_p[0];
      w_f    <= flags;
    end
  end

  // Stage 1: neighborhood sums of the centre left of the newest column and,
  // at the end of a row, of the newest column itself.
  logic signed [CSW-1:0] u2_g, u1_g, l2_g, l1_g;
  logic signed [SW-1:0]  ua_sum, ub_sum, la_sum, lb_sum;

  always_comb begin
    if (w_f.c_ge2) begin
      u2_g = w_u[2];
      l2_g = w_l[2];
    end else begin
      u2_g = '0;
      l2_g = '0;
    end
    if (w_f.c_ge1) begin
      u1_g = w_u[1];
      l1_g = w_l[1];
    end else begin
      u1_g = '0;
      l1_g = '0;
    end
    ua_sum = SW'(u2_g) + SW'(w_u[1]) + SW'(w_u[0]);
    ub_sum = SW'(u1_g) + SW'(w_u[0]);
    la_sum = SW'(l2_g) + SW'(w_l[1]) + SW'(w_l[0]);
    lb_sum = SW'(l1_g) + SW'(w_l[0]);
  end

  logic                         s2_valid, s2_last;
  logic                         s2_ua_ok, s2_ub_ok, s2_la_ok, s2_lb_ok;
  logic signed [SW-1:0]         s2_ua_sum, s2_ub_sum, s2_la_sum, s2_lb_sum;
  logic signed [PIXEL_BITS-1:0] s2_ua_ctr, s2_ub_ctr, s2_la_ctr, s2_lb_ctr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= acc;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_last   <= w_f.last_pix;
    s2_ua_ok  <= w_f.has_above1 && w_f.c_ge1;
    s2_ub_ok  <= w_f.has_above1 && w_f.last_col;
    s2_la_ok  <= w_f.last_row && w_f.c_ge1;
    s2_lb_ok  <= w_f.last_row && w_f.last_col;
    s2_ua_sum <= ua_sum;
    s2_ub_sum <= ub_sum;
    s2_la_sum <= la_sum;
    s2_lb_sum <= lb_sum;
    s2_ua_ctr <= w_n[1];
    s2_ub_ctr <= w_n[0];
    s2_la_ctr <= w_p[1];
    s2_lb_ctr <= w_p[0];
  end

  // Stage 2: the earlier of the two candidates wins unless the later one
  // is strictly larger.
  logic                         u_pick_b, l_pick_b;
  logic                         s3_valid, s3_last, s3_u_ok, s3_l_ok;
  logic signed [SW-1:0]         s3_u_sum, s3_l_sum;
  logic signed [PIXEL_BITS-1:0] s3_u_ctr, s3_l_ctr;

  assign u_pick_b = s2_ub_ok && (!s2_ua_ok || (s2_ub_sum > s2_ua_sum));
  assign l_pick_b = s2_lb_ok && (!s2_la_ok || (s2_lb_sum > s2_la_sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_last  <= s2_last;
    s3_u_ok  <= s2_ua_ok || s2_ub_ok;
    s3_l_ok  <= s2_la_ok || s2_lb_ok;
    s3_u_sum <= u_pick_b ? s2_ub_sum : s2_ua_sum;
    s3_u_ctr <= u_pick_b ? s2_ub_ctr : s2_ua_ctr;
    s3_l_sum <= l_pick_b ? s2_lb_sum : s2_la_sum;
    s3_l_ctr <= l_pick_b ? s2_lb_ctr : s2_la_ctr;
  end

  // Stage 3: running maxima of the two tracks.
  logic signed [SW-1:0]         best_u_sum, best_l_sum;
  logic signed [PIXEL_BITS-1:0] best_u_ctr, best_l_ctr;
  logic                         u_take, l_take;
  logic signed [SW-1:0]         nu_sum, nl_sum;
  logic signed [PIXEL_BITS-1:0] nu_ctr, nl_ctr;
  logic                         fin_valid;
  logic signed [SW-1:0]         fin_u_sum, fin_l_sum;
  logic signed [PIXEL_BITS-1:0] fin_u_ctr, fin_l_ctr;

  assign u_take = s3_u_ok && (s3_u_sum > best_u_sum);
  assign l_take = s3_l_ok && (s3_l_sum > best_l_sum);
  assign nu_sum = u_take ? s3_u_sum : best_u_sum;
  assign nu_ctr = u_take ? s3_u_ctr : best_u_ctr;
  assign nl_sum = l_take ? s3_l_sum : best_l_sum;
  assign nl_ctr = l_take ? s3_l_ctr : best_l_ctr;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best_u_sum <= SUM_MIN;
      best_l_sum <= SUM_MIN;
      fin_valid  <= 1'b0;
    end else begin
      fin_valid <= s3_valid && s3_last;
      if (s3_valid) begin
        if (s3_last) begin
          best_u_sum <= SUM_MIN;
          best_l_sum <= SUM_MIN;
        end else begin
          best_u_sum <= nu_sum;
          best_l_sum <= nl_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      best_u_ctr <= nu_ctr;
      best_l_ctr <= nl_ctr;
      fin_u_sum  <= nu_sum;
      fin_u_ctr  <= nu_ctr;
      fin_l_sum  <= nl_sum;
      fin_l_ctr  <= nl_ctr;
    end
  end

  // Stage 4: the bottom row comes last in raster order, so it only wins
  // when strictly larger.
  assign push        = fin_valid;
  assign push_sum    = (fin_l_sum > fin_u_sum) ? fin_l_sum : fin_u_sum;
  assign push_center = (fin_l_sum > fin_u_sum) ? fin_l_ctr : fin_u_ctr;

endmodule

### rtl/nsm_res_fifo.sv
// Small queue of finished result words in front of the output channel.
module nsm_res_fifo #(
  parameter int PIXEL_BITS = nsm_pkg::PIXEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic signed [PIXEL_BITS+3:0] push_sum,
  input  logic signed [PIXEL_BITS-1:0] push_center,
  nsm_res_if.source                    results
);

  localparam int PB = nsm_pkg::RES_PTR_BITS;

  logic signed [PIXEL_BITS+3:0] mem_sum [nsm_pkg::RES_DEPTH];
  logic signed [PIXEL_BITS-1:0] mem_ctr [nsm_pkg::RES_DEPTH];
  logic [PB-1:0]                wr_ptr, rd_ptr;
  logic [PB:0]                  count;
  logic                         pop;

  assign pop                  = results.valid && results.ready;
  assign results.valid        = (count != '0);
  assign results.max_sum      = mem_sum[rd_ptr];
  assign results.center_value = mem_ctr[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_sum[wr_ptr] <= push_sum;
      mem_ctr[wr_ptr] <= push_center;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PB'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PB'(1);
      end
      if (push && !pop) begin
        count <= count + (PB+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PB+1)'(1);
      end
    end
  end

endmodule
